/* hdl/crcgc_pkg.sv */
package crcgc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int GEN_W       = 32;
  localparam int DEGREE_W    = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_GENERATOR_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEGREE        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_MODE    = 2'd2;

  localparam logic [GEN_W-1:0]    GENERATOR_LOW_RST = 32'd7;
  localparam logic [DEGREE_W-1:0] DEGREE_RST        = 6'd8;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } in_t;

  typedef struct packed {
    logic out_bit;
    logic is_crc_bit;
    logic error_flag;
    logic last_out;
  } out_t;

  // classification of one queued transaction
  typedef struct packed {
    logic is_check;
    logic data_bit;
    logic last_bit;
    logic error_flag;
  } entry_ctl_t;

endpackage

/* hdl/crcgc_fifo.sv */
module crcgc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/crcgc_front.sv */
module crcgc_front #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crcgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [crcgc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  input  crcgc_pkg::in_t                      in_data,
  input  logic                                full,
  output logic                                in_stall,
  output logic                                push,
  output crcgc_pkg::entry_ctl_t               push_ctl,
  output logic [MAX_DEGREE-1:0]               push_rem,
  output logic [$clog2(MAX_DEGREE+1)-1:0]     push_deg
);

  import crcgc_pkg::*;

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic [GEN_W-1:0]      generator_low;
  logic [DEGREE_W-1:0]   degree;
  logic                  check_mode;
  logic [MAX_DEGREE-1:0] remainder;

  logic [DW-1:0]         d_eff;
  logic [DW-1:0]         d_m1;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] gen;
  logic [MAX_DEGREE-1:0] rem;
  logic [MAX_DEGREE-1:0] remainder_next;
  logic                  top;
  logic                  accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    if (degree == '0) begin
      d_eff = DW'(1);
    end else if ({1'b0, degree} > 7'(MAX_DEGREE)) begin
      d_eff = DW'(MAX_DEGREE);
    end else begin
      d_eff = DW'(degree);
    end
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (i < int'(d_eff));
    end
  end

  assign d_m1 = d_eff - DW'(1);
  assign gen  = MAX_DEGREE'(generator_low) & mask;
  assign rem  = remainder & mask;
  assign top  = rem[d_m1[IW-1:0]];

  // single XOR feedback; check mode divides the codeword directly,
  // generate mode divides message * x^d
  always_comb begin
    if (check_mode) begin
      remainder_next = ((rem << 1) | MAX_DEGREE'(in_data.data_bit)) & mask;
      if (top) begin
        remainder_next = remainder_next ^ gen;
      end
    end else begin
      remainder_next = (rem << 1) & mask;
      if (top ^ in_data.data_bit) begin
        remainder_next = remainder_next ^ gen;
      end
    end
  end

  // check mode queues nothing until the codeword ends
  assign push                = accept && !(check_mode && !in_data.last_bit);
  assign push_ctl.is_check   = check_mode;
  assign push_ctl.data_bit   = in_data.data_bit;
  assign push_ctl.last_bit   = in_data.last_bit;
  assign push_ctl.error_flag = (remainder_next != '0);
  assign push_rem            = remainder_next;
  assign push_deg            = d_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      generator_low <= GENERATOR_LOW_RST;
      degree        <= DEGREE_RST;
      check_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GENERATOR_LOW: generator_low <= cfg_data[GEN_W-1:0];
        CFG_DEGREE:        degree        <= cfg_data[DEGREE_W-1:0];
        CFG_CHECK_MODE:    check_mode    <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= in_data.last_bit ? '0 : remainder_next;
    end
  end

endmodule

/* hdl/crcgc_back.sv */
module crcgc_back #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            empty,
  input  crcgc_pkg::entry_ctl_t           rd_ctl,
  input  logic [MAX_DEGREE-1:0]           rd_rem,
  input  logic [$clog2(MAX_DEGREE+1)-1:0] rd_deg,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output crcgc_pkg::out_t                 out_data
);

  import crcgc_pkg::*;

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic                  crc_active;
  logic [MAX_DEGREE-1:0] crc_rem;
  logic [DW-1:0]         crc_left;
  logic [DW-1:0]         left_m1;
  logic                  can_load;

  assign can_load = !out_valid || !out_stall;
  assign left_m1  = crc_left - DW'(1);
  // hold the queue while the remainder is being shifted out
  assign pop      = !crc_active && !empty && can_load;

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (crc_active) begin
        out_data.out_bit    <= crc_rem[left_m1[IW-1:0]];
        out_data.is_crc_bit <= 1'b1;
        out_data.error_flag <= 1'b0;
        out_data.last_out   <= (crc_left == DW'(1));
      end else if (rd_ctl.is_check) begin
        out_data.out_bit    <= 1'b0;
        out_data.is_crc_bit <= 1'b0;
        out_data.error_flag <= rd_ctl.error_flag;
        out_data.last_out   <= 1'b1;
      end else begin
        out_data.out_bit    <= rd_ctl.data_bit;
        out_data.is_crc_bit <= 1'b0;
        out_data.error_flag <= 1'b0;
        out_data.last_out   <= 1'b0;
      end
    end
    if (pop) begin
      crc_rem <= rd_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      crc_active <= 1'b0;
      crc_left   <= '0;
    end else begin
      if (can_load) begin
        out_valid <= crc_active || !empty;
      end
      if (crc_active && can_load) begin
        crc_left <= left_m1;
        if (crc_left == DW'(1)) begin
          crc_active <= 1'b0;
        end
      end else if (pop && !rd_ctl.is_check && rd_ctl.last_bit) begin
        crc_active <= 1'b1;
        crc_left   <= rd_deg;
      end
    end
  end

endmodule

/* hdl/crc_generate_and_check_top.sv */
// channel  | valid      | stall      | payload
// ---------+------------+------------+---------------------------------------------
// input    | in_valid   | in_stall   | in_data  {data_bit, last_bit}
// output   | out_valid  | out_stall  | out_data {out_bit, is_crc_bit, error_flag, last_out}
// config   | cfg_we     | -          | cfg_index, cfg_data
//
// One input bit per cycle while in_stall is low; the remainder register updates in the
// cycle of acceptance. A generate-mode bit marked last is followed by its d CRC bits:
// the back end shifts the remainder out one bit a cycle unless out_stall holds it, while
// holding the two-entry queue. A result passes the queue, then the output register.
// rst is synchronous and restores the register defaults and an empty pipe.
// in_stall rises only when the queue is full; output stalls are absorbed by the queue.
module crc_generate_and_check_top #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crcgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crcgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  crcgc_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output crcgc_pkg::out_t                   out_data
);

  import crcgc_pkg::*;

  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int CTL_W = $bits(entry_ctl_t);
  localparam int QW    = CTL_W + MAX_DEGREE + DW;

  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  entry_ctl_t            push_ctl;
  logic [MAX_DEGREE-1:0] push_rem;
  logic [DW-1:0]         push_deg;
  entry_ctl_t            rd_ctl;
  logic [MAX_DEGREE-1:0] rd_rem;
  logic [DW-1:0]         rd_deg;
  logic [QW-1:0]         wr_word;
  logic [QW-1:0]         rd_word;

  assign wr_word = {push_ctl, push_rem, push_deg};
  assign rd_ctl  = rd_word[QW-1 -: CTL_W];
  assign rd_rem  = rd_word[DW +: MAX_DEGREE];
  assign rd_deg  = rd_word[DW-1:0];

  crcgc_front #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .full      (full),
    .in_stall  (in_stall),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_rem  (push_rem),
    .push_deg  (push_deg)
  );

  crcgc_fifo #(
    .W(QW)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_word),
    .pop     (pop),
    .rd_data (rd_word),
    .full    (full),
    .empty   (empty)
  );

  crcgc_back #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .rd_ctl    (rd_ctl),
    .rd_rem    (rd_rem),
    .rd_deg    (rd_deg),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_check_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_flag |-> out_data.last_out && !out_data.is_crc_bit)
    else $error("error flag on a result that is not a check verdict");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

endmodule
